// File: hw/rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared codes, state type and controller/datapath command and status structs
// for the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int ID_COUNT = 16;
    localparam int ID_W     = 4;

    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_REG_TAIL   = 2'd1;
    localparam logic [1:0] REQ_REG_HEAD   = 2'd2;
    localparam logic [1:0] REQ_UNREGISTER = 2'd3;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_REFUSED = 2'd1;
    localparam logic [1:0] KIND_DUE     = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_HEAD_RD,
        ST_HEAD_WR,
        ST_REM_RD,
        ST_REM_CHK,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_END,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_TAIL,
        WR_HEAD,
        WR_UP,
        WR_DOWN
    } wr_op_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_REQ,
        EMIT_PEND_MID,
        EMIT_END
    } emit_op_t;

    typedef struct packed {
        logic     load;
        logic     clk_add;
        logic     kind_load;
        logic     reg_commit;
        logic     unreg_commit;
        logic     cnt_dec;
        logic     found_upd;
        logic     stamp;
        logic     mem_rd;
        logic     rd_prev;
        wr_op_t   wr_op;
        idx_op_t  idx_op;
        emit_op_t emit_op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       refuse;
        logic       idx_zero;
        logic       idx_at_count;
        logic       found;
        logic       due;
        logic       pend_valid;
        logic       out_free;
    } stat_t;

endpackage

// File: hw/rtl/periodic_task_dispatcher.sv
// Sequence: a tail insert or refused request is decoded, then gives its result word;
// a head insert shifts stored tasks up from the tail, an unregister scans from the head
// moving later tasks down, a tick checks every stored task; results wait on m_ready.
// One request word at a time; the next is taken once the last result word is issued.
// Reset: synchronous active-low aresetn clears the clock, task count, flags and
// handshake state; task tables and run order are written before they are read.
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Cooperative periodic task scheduler with an ordered run table and a 64-bit
// microsecond clock.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [3:0]  s_task_id,
    input  logic [31:0] s_interval_usec,
    input  logic [31:0] s_tick_delta_usec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [3:0]  m_due_task,
    output logic        m_last_result
);

    ptd_pkg::cmd_t  cmd;
    ptd_pkg::stat_t stat;

    ptd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptd_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_req_type        (s_req_type),
        .s_task_id         (s_task_id),
        .s_interval_usec   (s_interval_usec),
        .s_tick_delta_usec (s_tick_delta_usec),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_due_task        (m_due_task),
        .m_last_result     (m_last_result)
    );

endmodule

// File: hw/rtl/ptd_datapath.sv
// ----------------------------------------------------------------------------
// ptd_datapath
// Run-order memory, task tables, microsecond clock, scan index and result
// register of the periodic task dispatcher.
// ----------------------------------------------------------------------------
module ptd_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptd_pkg::cmd_t        cmd,
    output ptd_pkg::stat_t       stat,
    input  logic [1:0]           s_req_type,
    input  logic [3:0]           s_task_id,
    input  logic [31:0]          s_interval_usec,
    input  logic [31:0]          s_tick_delta_usec,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_result_kind,
    output logic [3:0]           m_due_task,
    output logic                 m_last_result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

    logic [1:0]  req_type_reg;
    logic [3:0]  id_reg;
    logic [31:0] interval_reg;
    logic [31:0] delta_reg;
    logic [63:0] clock_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [ptd_pkg::ID_COUNT-1:0] flags_reg;
    logic [31:0] period_reg [ptd_pkg::ID_COUNT];
    logic [63:0] last_reg [ptd_pkg::ID_COUNT];
    logic [3:0]  run_order [MAX_TASKS];
    logic [3:0]  rd_data_reg;
    logic        found_reg;
    logic        pend_valid_reg;
    logic [3:0]  pend_id_reg;
    logic [1:0]  kind_reg;
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [3:0]  m_task_reg;
    logic        m_last_reg;

    logic [CW-1:0] idx_m1;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [3:0]    wr_data;
    logic [IW-1:0] rd_addr;
    logic [63:0]   elapsed;
    logic          due;
    logic          out_free;
    logic          emit;

    assign idx_m1   = idx_reg - 1'b1;
    assign elapsed  = clock_reg - last_reg[rd_data_reg];
    assign due      = elapsed >= {32'd0, period_reg[rd_data_reg]};
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = cmd.emit_op != ptd_pkg::EMIT_NONE;

    always_comb begin
        stat.req_type     = req_type_reg;
        stat.refuse       = (req_type_reg == ptd_pkg::REQ_UNREGISTER) ? !flags_reg[id_reg]
                          : (flags_reg[id_reg] || cnt_reg == CNT_MAX);
        stat.idx_zero     = idx_reg == '0;
        stat.idx_at_count = idx_reg == cnt_reg;
        stat.found        = found_reg;
        stat.due          = due;
        stat.pend_valid   = pend_valid_reg;
        stat.out_free     = out_free;
    end

    // run-order memory ports
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[IW-1:0];
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            ptd_pkg::WR_TAIL: begin
                wr_addr = cnt_reg[IW-1:0];
                wr_data = id_reg;
            end
            ptd_pkg::WR_HEAD: begin
                wr_addr = '0;
                wr_data = id_reg;
            end
            ptd_pkg::WR_UP:   wr_addr = idx_reg[IW-1:0];
            ptd_pkg::WR_DOWN: wr_addr = idx_m1[IW-1:0];
            default:          wr_en   = 1'b0;
        endcase
        rd_addr = cmd.rd_prev ? idx_m1[IW-1:0] : idx_reg[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            run_order[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= run_order[rd_addr];
        end
    end

    always_comb begin
        case (cmd.idx_op)
            ptd_pkg::IDX_ZERO:  idx_next = '0;
            ptd_pkg::IDX_COUNT: idx_next = cnt_reg;
            ptd_pkg::IDX_INC:   idx_next = idx_reg + 1'b1;
            ptd_pkg::IDX_DEC:   idx_next = idx_m1;
            default:            idx_next = idx_reg;
        endcase
    end

    // payload, task-table, index and result registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load) begin
            req_type_reg <= s_req_type;
            id_reg       <= s_task_id;
            interval_reg <= s_interval_usec;
            delta_reg    <= s_tick_delta_usec;
        end
        if (cmd.kind_load) begin
            kind_reg <= stat.refuse ? ptd_pkg::KIND_REFUSED : ptd_pkg::KIND_DONE;
        end
        if (cmd.reg_commit) begin
            period_reg[id_reg] <= interval_reg;
            last_reg[id_reg]   <= '0;
        end
        if (cmd.stamp) begin
            last_reg[rd_data_reg] <= clock_reg;
            pend_id_reg           <= rd_data_reg;
        end
        if (emit) begin
            case (cmd.emit_op)
                ptd_pkg::EMIT_REQ: begin
                    m_kind_reg <= kind_reg;
                    m_task_reg <= '0;
                    m_last_reg <= 1'b1;
                end
                ptd_pkg::EMIT_PEND_MID: begin
                    m_kind_reg <= ptd_pkg::KIND_DUE;
                    m_task_reg <= pend_id_reg;
                    m_last_reg <= 1'b0;
                end
                default: begin
                    m_kind_reg <= pend_valid_reg ? ptd_pkg::KIND_DUE : ptd_pkg::KIND_NONE;
                    m_task_reg <= pend_valid_reg ? pend_id_reg : 4'd0;
                    m_last_reg <= 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg      <= '0;
            cnt_reg        <= '0;
            flags_reg      <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clk_add) begin
                clock_reg <= clock_reg + {32'd0, delta_reg};
            end
            if (cmd.reg_commit) begin
                flags_reg[id_reg] <= 1'b1;
                cnt_reg           <= cnt_reg + 1'b1;
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.unreg_commit) begin
                flags_reg[id_reg] <= 1'b0;
            end
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (cmd.found_upd) begin
                found_reg <= found_reg || (rd_data_reg == id_reg);
            end
            if (cmd.stamp) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.emit_op == ptd_pkg::EMIT_END) begin
                pend_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_due_task    = m_task_reg;
    assign m_last_result = m_last_reg;

endmodule

// File: hw/rtl/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Request sequencer: decodes a request word and steps the datapath through
// insert, remove and scan passes over the run-order memory.
// ----------------------------------------------------------------------------
module ptd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ptd_pkg::stat_t  stat,
    output ptd_pkg::cmd_t   cmd
);

    ptd_pkg::state_t state_reg;
    ptd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptd_pkg::ST_IDLE: begin
                if (s_valid) state_next = ptd_pkg::ST_DECODE;
            end
            ptd_pkg::ST_DECODE: begin
                if (stat.req_type == ptd_pkg::REQ_TICK) begin
                    state_next = ptd_pkg::ST_TICK_RD;
                end else if (stat.refuse || stat.req_type == ptd_pkg::REQ_REG_TAIL) begin
                    state_next = ptd_pkg::ST_EMIT;
                end else if (stat.req_type == ptd_pkg::REQ_REG_HEAD) begin
                    state_next = ptd_pkg::ST_HEAD_RD;
                end else begin
                    state_next = ptd_pkg::ST_REM_RD;
                end
            end
            ptd_pkg::ST_HEAD_RD: begin
                state_next = stat.idx_zero ? ptd_pkg::ST_EMIT : ptd_pkg::ST_HEAD_WR;
            end
            ptd_pkg::ST_HEAD_WR: state_next = ptd_pkg::ST_HEAD_RD;
            ptd_pkg::ST_REM_RD: begin
                state_next = stat.idx_at_count ? ptd_pkg::ST_EMIT : ptd_pkg::ST_REM_CHK;
            end
            ptd_pkg::ST_REM_CHK: state_next = ptd_pkg::ST_REM_RD;
            ptd_pkg::ST_TICK_RD: begin
                state_next = stat.idx_at_count ? ptd_pkg::ST_TICK_END : ptd_pkg::ST_TICK_CHK;
            end
            ptd_pkg::ST_TICK_CHK: begin
                if (!(stat.due && stat.pend_valid && !stat.out_free)) begin
                    state_next = ptd_pkg::ST_TICK_RD;
                end
            end
            ptd_pkg::ST_TICK_END,
            ptd_pkg::ST_EMIT: begin
                if (stat.out_free) state_next = ptd_pkg::ST_IDLE;
            end
            default: state_next = ptd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.wr_op   = ptd_pkg::WR_NONE;
        cmd.idx_op  = ptd_pkg::IDX_HOLD;
        cmd.emit_op = ptd_pkg::EMIT_NONE;
        s_ready     = 1'b0;
        case (state_reg)
            ptd_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ptd_pkg::ST_DECODE: begin
                cmd.kind_load = 1'b1;
                if (stat.req_type == ptd_pkg::REQ_TICK) begin
                    cmd.clk_add = 1'b1;
                    cmd.idx_op  = ptd_pkg::IDX_ZERO;
                end else if (!stat.refuse) begin
                    case (stat.req_type)
                        ptd_pkg::REQ_REG_TAIL: begin
                            cmd.wr_op      = ptd_pkg::WR_TAIL;
                            cmd.reg_commit = 1'b1;
                        end
                        ptd_pkg::REQ_REG_HEAD: cmd.idx_op = ptd_pkg::IDX_COUNT;
                        default: begin
                            cmd.unreg_commit = 1'b1;
                            cmd.idx_op       = ptd_pkg::IDX_ZERO;
                        end
                    endcase
                end
            end
            ptd_pkg::ST_HEAD_RD: begin
                if (stat.idx_zero) begin
                    cmd.wr_op      = ptd_pkg::WR_HEAD;
                    cmd.reg_commit = 1'b1;
                end else begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_prev = 1'b1;
                end
            end
            ptd_pkg::ST_HEAD_WR: begin
                cmd.wr_op  = ptd_pkg::WR_UP;
                cmd.idx_op = ptd_pkg::IDX_DEC;
            end
            ptd_pkg::ST_REM_RD: begin
                if (stat.idx_at_count) begin
                    cmd.cnt_dec = 1'b1;
                end else begin
                    cmd.mem_rd = 1'b1;
                end
            end
            ptd_pkg::ST_REM_CHK: begin
                // entries after the removed id move down one place
                if (stat.found) cmd.wr_op = ptd_pkg::WR_DOWN;
                cmd.found_upd = 1'b1;
                cmd.idx_op    = ptd_pkg::IDX_INC;
            end
            ptd_pkg::ST_TICK_RD: begin
                cmd.mem_rd = !stat.idx_at_count;
            end
            ptd_pkg::ST_TICK_CHK: begin
                // a due id is held back until the next due id or scan end so the final one can carry last
                if (stat.due) begin
                    if (!stat.pend_valid || stat.out_free) begin
                        cmd.stamp   = 1'b1;
                        cmd.idx_op  = ptd_pkg::IDX_INC;
                        cmd.emit_op = stat.pend_valid ? ptd_pkg::EMIT_PEND_MID
                                                      : ptd_pkg::EMIT_NONE;
                    end
                end else begin
                    cmd.idx_op = ptd_pkg::IDX_INC;
                end
            end
            ptd_pkg::ST_TICK_END: begin
                if (stat.out_free) cmd.emit_op = ptd_pkg::EMIT_END;
            end
            ptd_pkg::ST_EMIT: begin
                if (stat.out_free) cmd.emit_op = ptd_pkg::EMIT_REQ;
            end
            default: begin
                cmd.wr_op = ptd_pkg::WR_NONE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks for the periodic task dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module ptd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_result_kind,
    input logic [3:0] m_due_task,
    input logic       m_last_result
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_due_task) && $stable(m_last_result))
        else $error("result word changed while stalled");

    // one request word in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready high right after accept");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != ptd_pkg::KIND_DUE |-> m_due_task == 4'd0)
        else $error("task id set on a non-due result");

    // only due words can be followed by more words of the same request
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != ptd_pkg::KIND_DUE |-> m_last_result)
        else $error("non-due result without last flag");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_due_task    (m_due_task),
    .m_last_result (m_last_result)
);
